// ----- sv/grid_astar_path_heading_macros.svh -----
// ----------------------------------------------------------------------------
// grid_astar_path_heading assertion macros
// Shorthand for clocked property checks; expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_HEADING_MACROS_SVH
`define GRID_ASTAR_PATH_HEADING_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define GAPH_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define GAPH_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/gaph_pkg.sv -----
// ----------------------------------------------------------------------------
// gaph_pkg
// Shared constants, entry types and the heading turn function.
// ----------------------------------------------------------------------------
package gaph_pkg;

  localparam int GRID_SIDE       = 8;
  localparam int CELLS           = GRID_SIDE * GRID_SIDE;
  localparam int COORD_W         = 3;
  localparam int CELL_W          = 2 * COORD_W;
  localparam int COST_W          = 10;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam logic [COST_W-1:0]  STEP_COST = 10'd10;
  localparam logic [COST_W-1:0]  COST_MAX  = 10'd1023;
  localparam logic [COORD_W-1:0] SIDE_MAX  = COORD_W'(GRID_SIDE - 1);

  localparam logic [2:0] CODE_OPEN      = 3'd0;
  localparam logic [2:0] CODE_WALL      = 3'd1;
  localparam logic [2:0] CODE_GOAL      = 3'd2;
  localparam logic [2:0] CODE_HEAD_BASE = 3'd3;

  localparam logic [1:0] HEAD_N = 2'd0;
  localparam logic [1:0] HEAD_E = 2'd1;
  localparam logic [1:0] HEAD_S = 2'd2;
  localparam logic [1:0] HEAD_W = 2'd3;

  localparam logic REG_WALL_MAP     = 1'b0;
  localparam logic REG_GOAL_HEADING = 1'b1;

  // One grid cell's scratch word.
  typedef struct packed {
    logic              closed;
    logic              pred_start;
    logic [CELL_W-1:0] pred;
    logic [COST_W-1:0] cost;
    logic              path_mark;
    logic [1:0]        heading;
  } cell_entry_t;

  // One open-list entry: path cost and cell.
  typedef struct packed {
    logic [COST_W-1:0] g;
    logic [CELL_W-1:0] loc;
  } queue_entry_t;

  // Context of one reported cell.
  typedef struct packed {
    logic [CELL_W-1:0] idx;
    logic              is_goal;
    logic              is_start;
    logic              is_wall;
    logic              found;
    logic [1:0]        heading;
  } out_req_t;

  // Heading after the step from node toward prev.
  function automatic logic [1:0] next_heading(input logic [1:0] hd,
                                              input logic [CELL_W-1:0] prev,
                                              input logic [CELL_W-1:0] node);
    logic vert, horiz, south, east;
    logic [1:0] res;
    vert  = prev[CELL_W-1:COORD_W] != node[CELL_W-1:COORD_W];
    horiz = prev[COORD_W-1:0] != node[COORD_W-1:0];
    south = prev[CELL_W-1:COORD_W] > node[CELL_W-1:COORD_W];
    east  = prev[COORD_W-1:0] > node[COORD_W-1:0];
    res   = hd;
    case (hd)
      HEAD_N: if (horiz && !vert) res = east ? hd + 2'd1 : hd - 2'd1;
      HEAD_E: if (vert && !horiz) res = south ? hd + 2'd1 : hd - 2'd1;
      HEAD_S: if (horiz && !vert) res = !east ? hd + 2'd1 : hd - 2'd1;
      default: if (vert && !horiz) res = !south ? hd + 2'd1 : hd - 2'd1;
    endcase
    return res;
  endfunction

endpackage

// ----- sv/gaph_out_stage.sv -----
// ----------------------------------------------------------------------------
// gaph_out_stage
// Cell code selection and the output register of the result stream.
// ----------------------------------------------------------------------------
module gaph_out_stage
  import gaph_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  cell_entry_t entry,
  input  out_req_t    req,
  output logic        ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // cell_row, cell_col, cell_code, zero pad
  output logic        m_tuser,  // found
  output logic        m_tlast
);

  logic [2:0] code;

  always_comb begin
    if (req.is_goal) begin
      code = CODE_GOAL;
    end else if (req.found && req.is_start) begin
      code = CODE_HEAD_BASE + {1'b0, req.heading};
    end else if (req.found && entry.path_mark) begin
      code = CODE_HEAD_BASE + {1'b0, entry.heading};
    end else if (req.is_wall) begin
      code = CODE_WALL;
    end else begin
      code = CODE_OPEN;
    end
  end

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {7'd0, code, req.idx[COORD_W-1:0], req.idx[CELL_W-1:COORD_W]};
      m_tuser <= req.found;
      m_tlast <= req.idx == CELL_W'(CELLS - 1);
    end
  end

endmodule

// ----- sv/grid_astar_path_heading.sv -----
// Flow: clear of the scratch words, then per expansion a read and check of each neighbor,
// a close of the cell, a scan of the open list for the best entry and a move of each
// later entry when it is removed; then backtrack steps and 64 reported cells.
// Throughput: one query at a time; the next is taken once the last cell is loaded.
// The open-list scan reads the scratch word of each entry's cell.
// Reset: synchronous; clears control, wall_map to 0 and goal_heading to south.
// ----------------------------------------------------------------------------
// grid_astar_path_heading
// A* search on an 8x8 grid, predecessor backtrack with heading turns, and a
// row-major stream of 64 cell codes per query.
// ----------------------------------------------------------------------------
module grid_astar_path_heading
  import gaph_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // start_row, start_col, goal_row, goal_col, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // cell_row, cell_col, cell_code, zero pad
  output logic        m_tuser,   // found
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [63:0] cfg_data
);

  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W = $clog2(CELLS + 1);

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_CLEAR    = 15'b000000000000010,
    ST_EXP_NB   = 15'b000000000000100,
    ST_EXP_CHK  = 15'b000000000001000,
    ST_CLOSE_RD = 15'b000000000010000,
    ST_CLOSE_WR = 15'b000000000100000,
    ST_SCAN_Q   = 15'b000000001000000,
    ST_SCAN_C   = 15'b000000010000000,
    ST_SCAN_CMP = 15'b000000100000000,
    ST_SHIFT_RD = 15'b000001000000000,
    ST_SHIFT_WR = 15'b000010000000000,
    ST_BT_RD    = 15'b000100000000000,
    ST_BT_WR    = 15'b001000000000000,
    ST_OUT_RD   = 15'b010000000000000,
    ST_OUT_LD   = 15'b100000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [63:0] wall_map;
  logic [1:0]  goal_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map     <= 64'd0;
      goal_heading <= HEAD_S;
    end else if (cfg_we) begin
      unique case (cfg_addr[0])
        REG_WALL_MAP:     wall_map     <= cfg_data;
        REG_GOAL_HEADING: goal_heading <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Scratch memory: one word per grid cell (cost, predecessor, closed, path).
  cell_entry_t       cell_mem [CELLS];
  logic              cm_we, cm_re;
  logic [CELL_W-1:0] cm_waddr, cm_raddr;
  cell_entry_t       cm_wdata, cm_rd;

  always_ff @(posedge clk) begin
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
    if (cm_re) cm_rd <= cell_mem[cm_raddr];
  end

  // Open list memory, kept in insertion order.
  queue_entry_t      q_mem [QUEUE_DEPTH];
  logic              q_we, q_re;
  logic [QIDX_W-1:0] q_waddr, q_raddr;
  queue_entry_t      q_wdata, q_rd;

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rd <= q_mem[q_raddr];
  end

  // Query and search registers.
  logic [CELL_W-1:0] start_cell, goal_cell, cur_cell, nb_cell;
  logic [COST_W-1:0] cur_g, nb_f, nb_gx, best_cost;
  logic [1:0]        nb_k, heading;
  logic [CNT_W-1:0]  q_count, scan_i, shift_j;
  logic [QIDX_W-1:0] best_i;
  queue_entry_t      best_entry;
  logic              found;
  logic [CELL_W-1:0] prev_cell, node_cell, out_idx, clr_idx;
  logic [STEP_W-1:0] steps;

  // Neighbor of the expanded cell: east, west, south, north.
  logic [COORD_W-1:0] cur_r, cur_c, nb_r, nb_c, goal_r, goal_c;
  logic               nb_ok;
  logic [CELL_W-1:0]  nb_n;
  logic [COST_W:0]    gx_sum, f_sum;
  logic [COST_W-1:0]  gx_sat, f_sat;
  logic [COORD_W:0]   manh;

  assign cur_r  = cur_cell[CELL_W-1:COORD_W];
  assign cur_c  = cur_cell[COORD_W-1:0];
  assign goal_r = goal_cell[CELL_W-1:COORD_W];
  assign goal_c = goal_cell[COORD_W-1:0];

  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    case (nb_k)
      2'd0: begin nb_c = cur_c + 3'd1; nb_ok = cur_c != SIDE_MAX; end
      2'd1: begin nb_c = cur_c - 3'd1; nb_ok = cur_c != '0; end
      2'd2: begin nb_r = cur_r + 3'd1; nb_ok = cur_r != SIDE_MAX; end
      default: begin nb_r = cur_r - 3'd1; nb_ok = cur_r != '0; end
    endcase
    nb_n = {nb_r, nb_c};
    manh = {1'b0, (goal_r > nb_r) ? goal_r - nb_r : nb_r - goal_r}
         + {1'b0, (goal_c > nb_c) ? goal_c - nb_c : nb_c - goal_c};
    gx_sum = {1'b0, cur_g} + {1'b0, STEP_COST};
    gx_sat = gx_sum > {1'b0, COST_MAX} ? COST_MAX : gx_sum[COST_W-1:0];
    f_sum  = {1'b0, gx_sat} + (COST_W + 1)'({manh, 1'b0});
    f_sat  = f_sum > {1'b0, COST_MAX} ? COST_MAX : f_sum[COST_W-1:0];
  end

  // Decisions on the neighbor word read back.
  logic improve, q_full, scan_sel, shift_more, os_ready, os_load;
  logic [CNT_W-1:0] shift_src;
  logic [1:0] hd_new;

  assign improve    = !cm_rd.closed && (cm_rd.cost == '0 || nb_f < cm_rd.cost);
  assign q_full     = q_count == CNT_W'(QUEUE_DEPTH);
  assign scan_sel   = scan_i == '0 || cm_rd.cost < best_cost;
  assign shift_src  = shift_j + CNT_W'(1);
  assign shift_more = shift_src < q_count;
  assign hd_new     = next_heading(heading, prev_cell, node_cell);
  assign os_load    = state == ST_OUT_LD && os_ready;
  assign s_tready   = state == ST_IDLE;

  // Memory port control.
  always_comb begin
    cm_we    = 1'b0;
    cm_re    = 1'b0;
    cm_waddr = cur_cell;
    cm_raddr = cur_cell;
    cm_wdata = cm_rd;
    q_we     = 1'b0;
    q_re     = 1'b0;
    q_waddr  = q_count[QIDX_W-1:0];
    q_raddr  = scan_i[QIDX_W-1:0];
    q_wdata  = '{g: nb_gx, loc: nb_cell};
    unique case (state)
      ST_CLEAR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_idx;
        cm_wdata = '0;
        cm_wdata.pred_start = clr_idx == start_cell;
      end
      ST_EXP_NB: begin
        cm_re    = nb_ok && !wall_map[nb_n];
        cm_raddr = nb_n;
      end
      ST_EXP_CHK: begin
        cm_we    = improve;
        cm_waddr = nb_cell;
        cm_wdata.cost       = nb_f;
        cm_wdata.pred       = cur_cell;
        cm_wdata.pred_start = 1'b0;
        q_we     = !cm_rd.closed && !(improve && nb_cell == goal_cell) && !q_full;
      end
      ST_CLOSE_RD: cm_re = 1'b1;
      ST_CLOSE_WR: begin
        cm_we = 1'b1;
        cm_wdata.closed = 1'b1;
      end
      ST_SCAN_Q: q_re = 1'b1;
      ST_SCAN_C: begin
        cm_re    = 1'b1;
        cm_raddr = q_rd.loc;
      end
      ST_SHIFT_RD: begin
        q_re    = shift_more;
        q_raddr = shift_src[QIDX_W-1:0];
      end
      ST_SHIFT_WR: begin
        q_we    = 1'b1;
        q_waddr = shift_j[QIDX_W-1:0];
        q_wdata = q_rd;
      end
      ST_BT_RD: begin
        cm_re    = steps != STEP_W'(CELLS);
        cm_raddr = node_cell;
      end
      ST_BT_WR: begin
        cm_we    = !cm_rd.pred_start;
        cm_waddr = node_cell;
        cm_wdata.path_mark = 1'b1;
        cm_wdata.heading   = hd_new;
      end
      ST_OUT_RD: begin
        cm_re    = 1'b1;
        cm_raddr = out_idx;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      q_count <= '0;
      found   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            // Hold the query; grid side is 8, so coordinates need no clamp.
            start_cell <= {s_tdata[2:0], s_tdata[5:3]};
            goal_cell  <= {s_tdata[8:6], s_tdata[11:9]};
            heading    <= goal_heading;
            clr_idx    <= '0;
            q_count    <= '0;
            found      <= 1'b0;
            state      <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          clr_idx <= clr_idx + CELL_W'(1);
          if (clr_idx == CELL_W'(CELLS - 1)) begin
            cur_cell <= start_cell;
            cur_g    <= '0;
            nb_k     <= '0;
            state    <= ST_EXP_NB;
          end
        end
        ST_EXP_NB: begin
          nb_cell <= nb_n;
          nb_f    <= f_sat;
          nb_gx   <= gx_sat;
          if (nb_ok && !wall_map[nb_n]) begin
            state <= ST_EXP_CHK;
          end else if (nb_k != 2'd3) begin
            nb_k <= nb_k + 2'd1;
          end else if (q_count != '0) begin
            state <= ST_CLOSE_RD;
          end else begin
            out_idx <= '0;
            state   <= ST_OUT_RD;
          end
        end
        ST_EXP_CHK: begin
          if (cm_rd.closed) begin
            // Skip a closed neighbor; advance to the next one, if any.
            if (nb_k != 2'd3) begin
              nb_k  <= nb_k + 2'd1;
              state <= ST_EXP_NB;
            end else if (q_count != '0) begin
              state <= ST_CLOSE_RD;
            end else begin
              out_idx <= '0;
              state   <= ST_OUT_RD;
            end
          end else if (improve && nb_cell == goal_cell) begin
            found     <= 1'b1;
            prev_cell <= goal_cell;
            node_cell <= cur_cell;
            steps     <= '0;
            state     <= ST_BT_RD;
          end else if (q_full) begin
            // Overflow ends the search without a path.
            out_idx <= '0;
            state   <= ST_OUT_RD;
          end else begin
            q_count <= q_count + CNT_W'(1);
            if (nb_k != 2'd3) begin
              nb_k  <= nb_k + 2'd1;
              state <= ST_EXP_NB;
            end else begin
              state <= ST_CLOSE_RD;
            end
          end
        end
        ST_CLOSE_RD: state <= ST_CLOSE_WR;
        ST_CLOSE_WR: begin
          scan_i <= '0;
          state  <= ST_SCAN_Q;
        end
        ST_SCAN_Q: state <= ST_SCAN_C;
        ST_SCAN_C: state <= ST_SCAN_CMP;
        ST_SCAN_CMP: begin
          // Strict compare keeps the earliest entry among equal costs.
          if (scan_sel) begin
            best_i     <= scan_i[QIDX_W-1:0];
            best_cost  <= cm_rd.cost;
            best_entry <= q_rd;
          end
          scan_i <= scan_i + CNT_W'(1);
          if (scan_i + CNT_W'(1) == q_count) begin
            shift_j <= scan_sel ? scan_i : CNT_W'(best_i);
            state   <= ST_SHIFT_RD;
          end else begin
            state <= ST_SCAN_Q;
          end
        end
        ST_SHIFT_RD: begin
          if (shift_more) begin
            state <= ST_SHIFT_WR;
          end else begin
            q_count  <= q_count - CNT_W'(1);
            cur_cell <= best_entry.loc;
            cur_g    <= best_entry.g;
            nb_k     <= '0;
            state    <= ST_EXP_NB;
          end
        end
        ST_SHIFT_WR: begin
          shift_j <= shift_src;
          state   <= ST_SHIFT_RD;
        end
        ST_BT_RD: begin
          if (steps == STEP_W'(CELLS)) begin
            out_idx <= '0;
            state   <= ST_OUT_RD;
          end else begin
            state <= ST_BT_WR;
          end
        end
        ST_BT_WR: begin
          if (cm_rd.pred_start) begin
            out_idx <= '0;
            state   <= ST_OUT_RD;
          end else begin
            heading   <= hd_new;
            prev_cell <= node_cell;
            node_cell <= cm_rd.pred;
            steps     <= steps + STEP_W'(1);
            state     <= ST_BT_RD;
          end
        end
        ST_OUT_RD: state <= ST_OUT_LD;
        ST_OUT_LD: begin
          if (os_ready) begin
            out_idx <= out_idx + CELL_W'(1);
            state   <= (out_idx == CELL_W'(CELLS - 1)) ? ST_IDLE : ST_OUT_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  out_req_t os_req;

  assign os_req = '{idx:      out_idx,
                    is_goal:  out_idx == goal_cell,
                    is_start: out_idx == start_cell,
                    is_wall:  wall_map[out_idx],
                    found:    found,
                    heading:  heading};

  gaph_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (os_load),
    .entry    (cm_rd),
    .req      (os_req),
    .ready    (os_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- sv/gaph_checker.sv -----
// ----------------------------------------------------------------------------
// gaph_checker
// Port-level checks of the planner, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_astar_path_heading_macros.svh"

module gaph_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic        cfg_we,
  input logic [0:0]  cfg_addr,
  input logic [63:0] cfg_data
);

  // An accepted query keeps the block busy.
  `GAPH_ASSERT_NEXT(a_busy_after_query, s_tvalid && s_tready, !s_tready, "ready after query")
  // A stalled result holds.
  `GAPH_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stall")
  // The final result is the bottom-right cell.
  `GAPH_ASSERT_SAME(a_last_cell, m_tvalid && m_tlast, m_tdata[5:0] == 6'h3f, "last cell")
  // No cell code beyond west heading.
  `GAPH_ASSERT_SAME(a_code_range, m_tvalid, m_tdata[8:6] != 3'd7, "cell code")

endmodule

bind grid_astar_path_heading gaph_checker u_gaph_checker (.*);
